// ===== rtl/core/path_turn_smoothing_metrics_top_defines.svh =====
// Assertion macros for the path turn smoothing metrics block.
// The clock and reset names clk_i and rst_ni are taken from the using module.
`ifndef PATH_TURN_SMOOTHING_METRICS_TOP_DEFINES_SVH
`define PATH_TURN_SMOOTHING_METRICS_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define PTSM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ptsm assertion failed");
// Check that a condition never holds outside reset.
`define PTSM_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("ptsm forbidden condition seen");
`else
`define PTSM_ASSERT(lbl, prop)
`define PTSM_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== rtl/core/ptsm_pkg.sv =====
package ptsm_pkg;

  // Path counter width and its full value
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned TURN_W = CNT_W + 3;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Field widths
  localparam int unsigned DIR_W     = 2;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned RTURN_W   = 18;
  localparam int unsigned SLEN_W    = 32;
  localparam int unsigned SCORE_W   = 32;

  // Shared multiplier and divider widths
  localparam int unsigned MUL_A_W = 24;
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned SSUM_W  = PROD_W + 1;
  localparam int unsigned TIME_W  = 59;
  localparam int unsigned QUO_W   = 57;
  localparam int unsigned DIVC_W  = 6;

  // Constants
  localparam logic [MUL_B_W-1:0] SQRT2_Q16    = 18'd92682;
  localparam logic [SLEN_W-1:0]  SLEN_MAX     = 32'hFFFF_0000;
  localparam logic [RTURN_W-1:0] TURN_OUT_MAX = '1;
  localparam logic [LEN_W-1:0]   LEN_OUT_MAX  = '1;
  localparam logic [LEN_W-1:0]   RAW_LEN_FULL = (CNT_W >= LEN_W) ? LEN_OUT_MAX :
                                                LEN_W'((32'd1 << CNT_W) - 32'd1);
  localparam logic [DIR_W-1:0]   DIR_OPP      = 2'd2;
  localparam logic [TURN_W-1:0]  TURN_OPP     = TURN_W'(4);
  localparam logic [TURN_W-1:0]  TURN_SIDE    = TURN_W'(2);

  localparam logic [CFG_W-1:0] LEN_WEIGHT_RST  = 24'd1016184;
  localparam logic [CFG_W-1:0] TURN_WEIGHT_RST = 24'd609509;
  localparam logic [CFG_W-1:0] TIME_OFFSET_RST = 24'd16777;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEN_WEIGHT  = 2'd0,
    CFG_TURN_WEIGHT = 2'd1,
    CFG_TIME_OFFSET = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ONE  = 2'd1,
    PH_RUN  = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SLEN_MUL,
    ST_SLEN_SUM,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_TURN,
    ST_ACC_TURN,
    ST_DIV,
    ST_LOAD
  } seq_state_e;

  // Path metrics with any open run closed, as seen at the last move
  typedef struct packed {
    logic [CNT_W-1:0]  move_count;
    logic [CNT_W-1:0]  diag_count;
    logic [CNT_W-1:0]  straight_count;
    logic [TURN_W-1:0] turn_sum;
    logic [TURN_W-1:0] turn_red;
    logic              overflow;
  } path_snap_t;

endpackage

// ===== rtl/core/ptsm_if.sv =====
interface ptsm_move_if import ptsm_pkg::*;;
  logic             valid;
  logic             ready;
  logic [DIR_W-1:0] move_dir;
  logic             last_move;

  modport source (output valid, move_dir, last_move, input ready);
  modport sink   (input valid, move_dir, last_move, output ready);
endinterface

interface ptsm_result_if import ptsm_pkg::*;;
  logic               valid;
  logic               ready;
  logic [LEN_W-1:0]   raw_length;
  logic [RTURN_W-1:0] raw_turns;
  logic [SLEN_W-1:0]  smooth_length;
  logic [RTURN_W-1:0] smooth_turns;
  logic [SCORE_W-1:0] score;
  logic               overflow;

  modport source (output valid, raw_length, raw_turns, smooth_length, smooth_turns, score,
                  overflow, input ready);
  modport sink   (input valid, raw_length, raw_turns, smooth_length, smooth_turns, score,
                  overflow, output ready);
endinterface

// ===== rtl/core/path_turn_smoothing_metrics_top.sv =====
// Path turn smoothing metrics.
// move_ch carries one grid move per beat (move_dir, last_move); result_ch
// carries one result beat per path, produced by the beat with last_move set.
// cfg_we_i/cfg_idx_i/cfg_data_i write the Q0.24 length weight (0), turn
// weight (1) and time offset (2); write them only while no path result is
// being worked out.
// Moves that do not end a path are taken one per cycle while the sequencer
// is idle. The last move starts a sequencer that runs a shared 24x18
// multiplier four times to build the smoothed length and the estimated time,
// then a restoring divider that produces one quotient bit per cycle, 57 bits
// in all. move_ch.ready stays low from the last move until the result is
// loaded into the output register, so no new move is taken before then.
// The result sits in an output register: while the receiver stalls, new
// moves are still taken, and only the next path's final load waits for it.
// Reset clears all path metrics, drops any pending result and loads the
// weights with their default values.
`include "path_turn_smoothing_metrics_top_defines.svh"

module path_turn_smoothing_metrics_top import ptsm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  ptsm_move_if.sink            move_ch,
  ptsm_result_if.source        result_ch
);

  seq_state_e         state_q, state_d;
  logic [DIVC_W-1:0]  cnt_q, cnt_d;
  logic [CFG_W-1:0]   lw_q, tw_q, off_q;
  path_snap_t         snap, snap_q;
  logic               in_fire, load, out_valid_q;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod_q;
  logic [SSUM_W-1:0]  slen_sum;
  logic [SLEN_W-1:0]  slen_q;
  logic [TURN_W-1:0]  turn_diff;
  logic [RTURN_W-1:0] sturns_q;
  logic [TIME_W-1:0]  time_q, rem_q, rem_nx;
  logic [TIME_W:0]    rem_sh;
  logic               rem_ge;
  logic [QUO_W-1:0]   quo_q;
  logic [SCORE_W-1:0] score;

  logic [LEN_W-1:0]   res_len_q;
  logic [RTURN_W-1:0] res_rturn_q, res_sturn_q;
  logic [SLEN_W-1:0]  res_slen_q;
  logic [SCORE_W-1:0] res_score_q;
  logic               res_ovf_q;

  function automatic logic [RTURN_W-1:0] sat_turn(input logic [TURN_W-1:0] v);
    return (32'(v) > 32'(TURN_OUT_MAX)) ? TURN_OUT_MAX : RTURN_W'(v);
  endfunction

  assign move_ch.ready = (state_q == ST_IDLE);
  assign in_fire       = move_ch.valid && move_ch.ready;

  ptsm_path u_path (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .dir_i  (move_ch.move_dir),
    .last_i (move_ch.last_move),
    .snap_o (snap)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q  <= LEN_WEIGHT_RST;
      tw_q  <= TURN_WEIGHT_RST;
      off_q <= TIME_OFFSET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LEN_WEIGHT:  lw_q  <= cfg_data_i;
        CFG_TURN_WEIGHT: tw_q  <= cfg_data_i;
        CFG_TIME_OFFSET: off_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Shared multiplier operand select
  always_comb begin
    unique case (state_q)
      ST_SLEN_MUL: begin
        mul_a = MUL_A_W'(snap_q.diag_count);
        mul_b = SQRT2_Q16;
      end
      ST_MUL_LO: begin
        mul_a = lw_q;
        mul_b = MUL_B_W'(slen_q[15:0]);
      end
      ST_MUL_HI: begin
        mul_a = lw_q;
        mul_b = MUL_B_W'(slen_q[31:16]);
      end
      ST_MUL_TURN: begin
        mul_a = tw_q;
        mul_b = sturns_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Smoothed length and turns
  assign slen_sum  = SSUM_W'(prod_q) + (SSUM_W'(snap_q.straight_count) << 16);
  assign turn_diff = (snap_q.turn_sum > snap_q.turn_red) ?
                     (snap_q.turn_sum - snap_q.turn_red) : '0;

  // One restoring division step: shift in a dividend bit, subtract if it fits
  assign rem_sh = {rem_q, (cnt_q == DIVC_W'(QUO_W - 1))};
  assign rem_ge = (rem_sh >= (TIME_W + 1)'(time_q));
  assign rem_nx = rem_ge ? TIME_W'(rem_sh - (TIME_W + 1)'(time_q)) : TIME_W'(rem_sh);

  // Saturate the quotient; zero time gives zero
  always_comb begin
    if (time_q == '0) begin
      score = '0;
    end else if (|quo_q[QUO_W-1:SCORE_W]) begin
      score = '1;
    end else begin
      score = quo_q[SCORE_W-1:0];
    end
  end

  assign load = (state_q == ST_LOAD) && (!out_valid_q || result_ch.ready);

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE:     if (in_fire && move_ch.last_move) state_d = ST_SLEN_MUL;
      ST_SLEN_MUL: state_d = ST_SLEN_SUM;
      ST_SLEN_SUM: state_d = ST_MUL_LO;
      ST_MUL_LO:   state_d = ST_MUL_HI;
      ST_MUL_HI:   state_d = ST_MUL_TURN;
      ST_MUL_TURN: state_d = ST_ACC_TURN;
      ST_ACC_TURN: begin
        cnt_d   = DIVC_W'(QUO_W - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = ST_LOAD;
      end
      ST_LOAD:     if (load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (result_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (in_fire && move_ch.last_move) begin
      snap_q <= snap;
    end
    unique case (state_q)
      ST_SLEN_SUM: begin
        slen_q   <= (slen_sum > SSUM_W'(SLEN_MAX)) ? SLEN_MAX : SLEN_W'(slen_sum);
        sturns_q <= sat_turn(turn_diff);
      end
      ST_MUL_LO:   time_q <= TIME_W'(off_q) << 16;
      ST_MUL_HI:   time_q <= time_q + TIME_W'(prod_q);
      ST_MUL_TURN: time_q <= time_q + (TIME_W'(prod_q) << 16);
      ST_ACC_TURN: begin
        time_q <= time_q + (TIME_W'(prod_q) << 16);
        rem_q  <= '0;
        quo_q  <= '0;
      end
      ST_DIV: begin
        rem_q <= rem_nx;
        quo_q <= {quo_q[QUO_W-2:0], rem_ge};
      end
      default: ;
    endcase
    if (load) begin
      res_len_q   <= (32'(snap_q.move_count) > 32'(LEN_OUT_MAX)) ?
                     LEN_OUT_MAX : LEN_W'(snap_q.move_count);
      res_rturn_q <= sat_turn(snap_q.turn_sum);
      res_slen_q  <= slen_q;
      res_sturn_q <= sturns_q;
      res_score_q <= score;
      res_ovf_q   <= snap_q.overflow;
    end
  end

  // Drive the result channel
  assign result_ch.valid         = out_valid_q;
  assign result_ch.raw_length    = res_len_q;
  assign result_ch.raw_turns     = res_rturn_q;
  assign result_ch.smooth_length = res_slen_q;
  assign result_ch.smooth_turns  = res_sturn_q;
  assign result_ch.score         = res_score_q;
  assign result_ch.overflow      = res_ovf_q;

  // Checks
  `PTSM_ASSERT(a_last_starts_seq, (in_fire && move_ch.last_move) |=> (state_q == ST_SLEN_MUL))
  `PTSM_ASSERT(a_div_ends_in_load, (state_q == ST_DIV && cnt_q == '0) |=> (state_q == ST_LOAD))
  `PTSM_ASSERT_NEVER(a_smooth_le_raw, result_ch.valid && (result_ch.smooth_turns > result_ch.raw_turns))
  `PTSM_ASSERT_NEVER(a_ovf_full_len, result_ch.valid && result_ch.overflow && (result_ch.raw_length != RAW_LEN_FULL))

endmodule

// ===== rtl/core/ptsm_path.sv =====
module ptsm_path import ptsm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [DIR_W-1:0] dir_i,
  input  logic             last_i,
  output path_snap_t       snap_o
);

  phase_e            phase_q, n_phase;
  logic [DIR_W-1:0]  pm_q, ppm_q, n_pm, n_ppm;
  logic [CNT_W-1:0]  run_q, mc_q, dg_q, st_q;
  logic [CNT_W-1:0]  n_run, n_mc, n_dg, n_st;
  logic [TURN_W-1:0] ts_q, tr_q, n_ts, n_tr;
  logic              ovf_q, n_ovf;

  // Apply one move to the path metrics
  always_comb begin
    n_phase = phase_q;
    n_pm    = pm_q;
    n_ppm   = ppm_q;
    n_run   = run_q;
    n_mc    = mc_q;
    n_dg    = dg_q;
    n_st    = st_q;
    n_ts    = ts_q;
    n_tr    = tr_q;
    n_ovf   = ovf_q;
    if (mc_q == CNT_MAX) begin
      n_ovf = 1'b1;
    end else begin
      n_mc = mc_q + 1'b1;
      if ((phase_q == PH_ONE || phase_q == PH_RUN) && dir_i != pm_q) begin
        n_ts = ts_q + (((dir_i ^ pm_q) == DIR_OPP) ? TURN_OPP : TURN_SIDE);
      end
      unique case (phase_q)
        PH_ONE: begin
          if (dir_i == pm_q) begin
            n_st = st_q + 1'b1;
          end else begin
            n_ppm   = pm_q;
            n_pm    = dir_i;
            n_run   = CNT_W'(2);
            n_phase = PH_RUN;
          end
        end
        PH_RUN: begin
          if (dir_i == ppm_q) begin
            n_run = run_q + 1'b1;
            n_ppm = pm_q;
            n_pm  = dir_i;
          end else begin
            // close the alternating run
            n_dg = dg_q + (run_q >> 1);
            n_st = st_q + CNT_W'(run_q[0]);
            if (run_q > CNT_W'(2)) begin
              n_tr = tr_q + (TURN_W'(run_q) << 1) - TURN_W'(4);
            end
            n_run   = '0;
            n_pm    = dir_i;
            n_phase = PH_ONE;
          end
        end
        default: begin
          n_pm    = dir_i;
          n_phase = PH_ONE;
        end
      endcase
    end
  end

  // Close whatever the path holds at its end
  always_comb begin
    snap_o.move_count     = n_mc;
    snap_o.diag_count     = n_dg;
    snap_o.straight_count = n_st;
    snap_o.turn_sum       = n_ts;
    snap_o.turn_red       = n_tr;
    snap_o.overflow       = n_ovf;
    if (n_phase == PH_ONE) begin
      snap_o.straight_count = n_st + 1'b1;
    end else if (n_phase == PH_RUN) begin
      snap_o.diag_count     = n_dg + (n_run >> 1);
      snap_o.straight_count = n_st + CNT_W'(n_run[0]);
      if (n_run > CNT_W'(2)) begin
        snap_o.turn_red = n_tr + (TURN_W'(n_run) << 1) - TURN_W'(4);
      end
    end
  end

  // Advance on each beat; clear after the last move
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pm_q    <= '0;
      ppm_q   <= '0;
      run_q   <= '0;
      mc_q    <= '0;
      dg_q    <= '0;
      st_q    <= '0;
      ts_q    <= '0;
      tr_q    <= '0;
      ovf_q   <= 1'b0;
    end else if (fire_i) begin
      if (last_i) begin
        phase_q <= PH_IDLE;
        pm_q    <= '0;
        ppm_q   <= '0;
        run_q   <= '0;
        mc_q    <= '0;
        dg_q    <= '0;
        st_q    <= '0;
        ts_q    <= '0;
        tr_q    <= '0;
        ovf_q   <= 1'b0;
      end else begin
        phase_q <= n_phase;
        pm_q    <= n_pm;
        ppm_q   <= n_ppm;
        run_q   <= n_run;
        mc_q    <= n_mc;
        dg_q    <= n_dg;
        st_q    <= n_st;
        ts_q    <= n_ts;
        tr_q    <= n_tr;
        ovf_q   <= n_ovf;
      end
    end
  end

endmodule
